/* design/mrkt_pkg.sv */
`default_nettype none

package mrkt_pkg;

    localparam int KNOB_COUNT_DEF = 128;
    localparam int BUTTON_COUNT   = 128;

    // Queue between the decoder and the executor; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_CTRL_CHG = 4'hB;

    localparam logic [1:0] FULL_MSG_BYTES = 2'd3;

    localparam logic [0:0] KIND_MIDI = 1'b0;
    localparam logic [0:0] KIND_SET  = 1'b1;

    localparam logic [0:0] CFG_FLOOR   = 1'b0;
    localparam logic [0:0] CFG_CEILING = 1'b1;

    localparam logic [7:0] FLOOR_RST   = 8'd0;
    localparam logic [7:0] CEILING_RST = 8'd128;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TURN    = 3'd1,
        EV_PRESS   = 3'd2,
        EV_RELEASE = 3'd3,
        EV_SET     = 3'd4
    } event_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        event_t     op;
        logic [6:0] idx;
        logic [6:0] d2;
        logic [7:0] setv;
    } item_t;

endpackage

`default_nettype wire

/* design/mrkt_decode.sv */
`default_nettype none

module mrkt_decode #(
    parameter int KNOB_COUNT = mrkt_pkg::KNOB_COUNT_DEF
) (
    input  wire logic [0:0]     kind,
    input  wire logic [7:0]     status_byte,
    input  wire logic [6:0]     data1,
    input  wire logic [6:0]     data2,
    input  wire logic [1:0]     byte_count,
    input  wire logic [7:0]     set_value,
    output mrkt_pkg::item_t     item
);
    import mrkt_pkg::*;

    logic       knob_ok;
    logic [3:0] msg_type;

    assign knob_ok  = ({1'b0, data1} < 8'(KNOB_COUNT));
    assign msg_type = status_byte[7:4];

    always_comb
    begin
        item.idx  = data1;
        item.d2   = data2;
        item.setv = set_value;
        item.op   = EV_NONE;
        if (kind == KIND_SET)
        begin
            item.op = knob_ok ? EV_SET : EV_NONE;
        end
        else if (byte_count == FULL_MSG_BYTES)
        begin
            case (msg_type)
                TYPE_CTRL_CHG: item.op = knob_ok ? EV_TURN : EV_NONE;
                TYPE_NOTE_ON:  item.op = (data2 != 7'd0) ? EV_PRESS : EV_RELEASE;
                TYPE_NOTE_OFF: item.op = EV_RELEASE;
                default:       item.op = EV_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/mrkt_queue.sv */
`default_nettype none

module mrkt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mrkt_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output mrkt_pkg::item_t      pop_item
);
    import mrkt_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/mrkt_exec.sv */
`default_nettype none

module mrkt_exec #(
    parameter int KNOB_COUNT = mrkt_pkg::KNOB_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      knob_floor,
    input  wire logic [7:0]      knob_ceiling,
    input  wire logic            item_valid,
    input  wire mrkt_pkg::item_t item,
    output logic                 item_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [2:0]           event_res,
    output logic [6:0]           index,
    output logic [7:0]           knob_level,
    output logic [6:0]           button_level
);
    import mrkt_pkg::*;

    localparam int KIDX_W = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;

    typedef enum logic [0:0] {
        ST_FETCH,
        ST_APPLY
    } state_t;

    state_t            state_reg;
    item_t             cur_reg;
    logic [7:0]        knob_rd_reg;
    logic              knob_rd_vld_reg;
    logic [KNOB_COUNT-1:0] knob_vld_reg;

    logic [7:0]        knob_mem [KNOB_COUNT];
    logic [6:0]        button_mem [BUTTON_COUNT];

    logic              out_vld_reg;
    logic [2:0]        event_reg;
    logic [6:0]        index_reg;
    logic [7:0]        knob_level_reg;
    logic [6:0]        button_level_reg;

    logic [KIDX_W-1:0] fetch_addr;
    logic [KIDX_W-1:0] cur_addr;
    logic [7:0]        old_level;
    logic signed [9:0] turn_sum;
    logic [7:0]        turn_level;
    logic [7:0]        set_raised;
    logic [7:0]        set_level;
    logic              apply_go;
    logic              knob_write;
    logic              button_write;
    logic [7:0]        new_level;

    assign fetch_addr = item.idx[KIDX_W-1:0];
    assign cur_addr   = cur_reg.idx[KIDX_W-1:0];
    assign item_pop   = (state_reg == ST_FETCH) && item_valid;
    assign apply_go   = (state_reg == ST_APPLY) && (!out_vld_reg || out_ready);

    // An entry never written since reset reads as zero.
    assign old_level = knob_rd_vld_reg ? knob_rd_reg : 8'd0;

    always_comb
    begin
        // The encoder value read as a signed 7-bit number is already the step.
        turn_sum = $signed({2'b00, old_level})
                 + $signed({{3{cur_reg.d2[6]}}, cur_reg.d2});
        if (turn_sum > $signed({2'b00, knob_ceiling}))
        begin
            turn_level = knob_ceiling;
        end
        else if (turn_sum < $signed({2'b00, knob_floor}))
        begin
            turn_level = knob_floor;
        end
        else
        begin
            turn_level = turn_sum[7:0];
        end

        set_raised = (cur_reg.setv < knob_floor) ? knob_floor : cur_reg.setv;
        set_level  = (set_raised > knob_ceiling) ? knob_ceiling : set_raised;

        knob_write   = (cur_reg.op == EV_TURN) || (cur_reg.op == EV_SET);
        button_write = (cur_reg.op == EV_PRESS) || (cur_reg.op == EV_RELEASE);
        new_level    = (cur_reg.op == EV_SET) ? set_level : turn_level;
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            knob_rd_reg <= knob_mem[fetch_addr];
            cur_reg     <= item;
        end
        if (apply_go && knob_write)
        begin
            knob_mem[cur_addr] <= new_level;
        end
        if (apply_go && button_write)
        begin
            button_mem[cur_reg.idx] <= cur_reg.d2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FETCH;
            knob_vld_reg     <= '0;
            knob_rd_vld_reg  <= 1'b0;
            out_vld_reg      <= 1'b0;
            event_reg        <= '0;
            index_reg        <= '0;
            knob_level_reg   <= '0;
            button_level_reg <= '0;
        end
        else
        begin
            if (out_vld_reg && out_ready && !apply_go)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_FETCH:
                begin
                    if (item_pop)
                    begin
                        knob_rd_vld_reg <= knob_vld_reg[fetch_addr];
                        state_reg       <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (apply_go)
                    begin
                        out_vld_reg      <= 1'b1;
                        event_reg        <= cur_reg.op;
                        index_reg        <= (cur_reg.op == EV_NONE) ? 7'd0 : cur_reg.idx;
                        knob_level_reg   <= knob_write ? new_level : 8'd0;
                        button_level_reg <= button_write ? cur_reg.d2 : 7'd0;
                        if (knob_write)
                        begin
                            knob_vld_reg[cur_addr] <= 1'b1;
                        end
                        state_reg <= ST_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= ST_FETCH;
                end
            endcase
        end
    end

    assign out_valid    = out_vld_reg;
    assign event_res    = event_reg;
    assign index        = index_reg;
    assign knob_level   = knob_level_reg;
    assign button_level = button_level_reg;

endmodule

`default_nettype wire

/* design/midi_relative_knob_tracker.sv */
// A request accepted into the queue is fetched by the executor, which reads its knob,
// and its result is registered when the executor writes the knob table back.
// The executor alternates between the read and the write-back, so it takes no new request until the last one is done.
// A two-entry queue lets input be accepted while the output is stalled.
// Reset (rst_n, asynchronous, active low) empties the queue, clears every knob
// level to zero, and sets the floor to 0 and the ceiling to 128.
`default_nettype none

module midi_relative_knob_tracker #(
    parameter int KNOB_COUNT = mrkt_pkg::KNOB_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] status_byte, [14:8] data1, [21:15] data2, [23:22] byte_count,
    // [31:24] set_value
    input  wire logic [31:0] s_axis_tdata,
    // [0] kind
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] index, [14:7] knob_level, [21:15] button_level, [23:22] zero
    output logic [23:0]      m_axis_tdata,
    // [2:0] event_res
    output logic [2:0]       m_axis_tuser
);
    import mrkt_pkg::*;

    logic [7:0] floor_reg;
    logic [7:0] ceiling_reg;
    item_t      dec_item;
    item_t      q_item;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       push;
    logic [6:0] index;
    logic [7:0] knob_level;
    logic [6:0] button_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RST;
            ceiling_reg <= CEILING_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_FLOOR:   floor_reg   <= cfg_wdata;
                CFG_CEILING: ceiling_reg <= cfg_wdata;
                default:     floor_reg   <= floor_reg;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    mrkt_decode #(
        .KNOB_COUNT (KNOB_COUNT)
    ) u_decode (
        .kind        (s_axis_tuser),
        .status_byte (s_axis_tdata[7:0]),
        .data1       (s_axis_tdata[14:8]),
        .data2       (s_axis_tdata[21:15]),
        .byte_count  (s_axis_tdata[23:22]),
        .set_value   (s_axis_tdata[31:24]),
        .item        (dec_item)
    );

    mrkt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (dec_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    mrkt_exec #(
        .KNOB_COUNT (KNOB_COUNT)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .knob_floor   (floor_reg),
        .knob_ceiling (ceiling_reg),
        .item_valid   (q_not_empty),
        .item         (q_item),
        .item_pop     (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .event_res    (m_axis_tuser),
        .index        (index),
        .knob_level   (knob_level),
        .button_level (button_level)
    );

    assign m_axis_tdata = {2'b00, button_level, knob_level, index};

endmodule

`default_nettype wire

/* dv/knob_event_checker.sv */
module knob_event_checker #(
    parameter int KNOB_TOTAL = mrkt_pkg::KNOB_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mrkt_pkg::*;

    typedef struct {
        event_t     ev;
        logic [6:0] idx;
        logic [7:0] knob;
        logic [6:0] btn;
    } knob_event_t;

    logic [7:0]  knob_tab [128];
    logic [6:0]  btn_tab [BUTTON_COUNT];
    logic [7:0]  floor_lvl;
    logic [7:0]  ceiling_lvl;
    knob_event_t expected_events [$];
    int          fail_total = 0;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want_v));
    endtask

    // Updates the tracked knob and button levels and returns the event the request causes.
    function automatic knob_event_t predict_knob_event(logic kind, logic [31:0] req);
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  count;
        logic [7:0]  setv;
        int          lvl;
        knob_event_t res;
        status  = req[7:0];
        d1      = req[14:8];
        d2      = req[21:15];
        count   = req[23:22];
        setv    = req[31:24];
        res.ev   = EV_NONE;
        res.idx  = '0;
        res.knob = '0;
        res.btn  = '0;
        if (kind == KIND_SET)
        begin
            if (int'(d1) < KNOB_TOTAL)
            begin
                // Raise to the floor first, so the ceiling wins when they cross.
                lvl = int'(setv);
                if (lvl < int'(floor_lvl))
                    lvl = int'(floor_lvl);
                if (lvl > int'(ceiling_lvl))
                    lvl = int'(ceiling_lvl);
                knob_tab[d1] = lvl[7:0];
                res.ev   = EV_SET;
                res.idx  = d1;
                res.knob = lvl[7:0];
            end
        end
        else if (count == FULL_MSG_BYTES)
        begin
            if (status[7:4] == TYPE_CTRL_CHG)
            begin
                if (int'(d1) < KNOB_TOTAL)
                begin
                    // Relative encoder: values from 64 upwards are negative steps.
                    lvl = int'(knob_tab[d1]);
                    if (d2 < 7'd64)
                        lvl = lvl + int'(d2);
                    else
                        lvl = lvl - (128 - int'(d2));
                    // The ceiling is checked first and wins only if the level exceeds it.
                    if (lvl > int'(ceiling_lvl))
                        lvl = int'(ceiling_lvl);
                    else if (lvl < int'(floor_lvl))
                        lvl = int'(floor_lvl);
                    knob_tab[d1] = lvl[7:0];
                    res.ev   = EV_TURN;
                    res.idx  = d1;
                    res.knob = lvl[7:0];
                end
            end
            else if (status[7:4] == TYPE_NOTE_ON || status[7:4] == TYPE_NOTE_OFF)
            begin
                btn_tab[d1] = d2;
                res.ev  = (status[7:4] == TYPE_NOTE_ON && d2 != 7'd0) ? EV_PRESS : EV_RELEASE;
                res.idx = d1;
                res.btn = d2;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        knob_event_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 128; i++)
            begin
                knob_tab[i] = '0;
                btn_tab[i]  = '0;
            end
            floor_lvl   = FLOOR_RST;
            ceiling_lvl = CEILING_RST;
            expected_events.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_addr == CFG_FLOOR)
                    floor_lvl = cfg_wdata;
                else if (cfg_addr == CFG_CEILING)
                    ceiling_lvl = cfg_wdata;
            end
            // A result can never belong to a request accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "result with no request waiting (event %0d, index %0d)",
                        m_axis_tuser, m_axis_tdata[6:0]));
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event", {5'b0, m_axis_tuser}, {5'b0, want.ev});
                    check_field("index", {1'b0, m_axis_tdata[6:0]}, {1'b0, want.idx});
                    check_field("knob level", m_axis_tdata[14:7], want.knob);
                    check_field("button level", {1'b0, m_axis_tdata[21:15]}, {1'b0, want.btn});
                    check_field("padding", {6'b0, m_axis_tdata[23:22]}, 8'd0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_events.push_back(predict_knob_event(s_axis_tuser[0], s_axis_tdata));
            outstanding <= expected_events.size();
        end
        mismatches <= fail_total;
    end

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mrkt_pkg::*;

    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int PHASE_COUNT      = 7;
    localparam int SETTLE_CYCLES    = 4;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [0:0]  cfg_addr      = CFG_FLOOR;
    logic [7:0]  cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] status_byte, [14:8] data1, [21:15] data2, [23:22] byte_count, [31:24] set_value
    logic [31:0] s_axis_tdata  = '0;
    // [0] kind
    logic [0:0]  s_axis_tuser  = KIND_MIDI;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [6:0] index, [14:7] knob_level, [21:15] button_level, [23:22] zero
    logic [23:0] m_axis_tdata;
    // [2:0] event_res
    logic [2:0]  m_axis_tuser;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit tx_quiet    = 1'b0;
    int n_turn      = 0;
    int n_note      = 0;
    int n_set       = 0;
    int n_none      = 0;
    int n_phase     = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    midi_relative_knob_tracker #(
        .KNOB_COUNT(KNOB_COUNT_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    knob_event_checker #(
        .KNOB_TOTAL(KNOB_COUNT_DEF)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 10);
        return $urandom_range(25, 70);
    endfunction

    task automatic send_request(logic kind, logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                                logic [1:0] count, logic [7:0] setv);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {setv, count, d2, d1, status};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        if (kind == KIND_SET)
            n_set++;
        else if (count != FULL_MSG_BYTES)
            n_none++;
        else if (status[7:4] == TYPE_CTRL_CHG)
            n_turn++;
        else if (status[7:4] == TYPE_NOTE_ON || status[7:4] == TYPE_NOTE_OFF)
            n_note++;
        else
            n_none++;
    endtask

    // Holds the sender off until every request has produced its result.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(logic [7:0] floor_v, logic [7:0] ceiling_v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FLOOR;
        cfg_wdata <= floor_v;
        @(posedge clk);
        cfg_addr  <= CFG_CEILING;
        cfg_wdata <= ceiling_v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        n_phase++;
    endtask

    task automatic send_random_request();
        int         r;
        logic       kind;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [1:0] count;
        logic [7:0] setv;
        kind   = KIND_MIDI;
        status = 8'($urandom_range(0, 255));
        d1     = 7'($urandom_range(0, 127));
        d2     = 7'($urandom_range(0, 127));
        count  = FULL_MSG_BYTES;
        setv   = 8'($urandom_range(0, 255));
        // Half the requests go to a handful of knobs so that levels build up and hit the bounds.
        if ($urandom_range(0, 1) == 0)
            d1 = 7'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            status = {TYPE_CTRL_CHG, status[3:0]};
            case ($urandom_range(0, 7))
                0: d2 = 7'd0;
                1: d2 = 7'd63;
                2: d2 = 7'd64;
                3: d2 = 7'd127;
                default: ;
            endcase
        end
        else if (r < 55)
        begin
            status = {($urandom_range(0, 1) != 0) ? TYPE_NOTE_ON : TYPE_NOTE_OFF, status[3:0]};
            if ($urandom_range(0, 4) == 0)
                d2 = 7'd0;
        end
        else if (r < 80)
        begin
            kind  = KIND_SET;
            count = 2'($urandom_range(0, 3));
        end
        else if (r < 90)
        begin
            status = {($urandom_range(0, 1) != 0) ? TYPE_CTRL_CHG : TYPE_NOTE_ON, status[3:0]};
            count  = 2'($urandom_range(0, 2));
        end
        else
        begin
            count = 2'($urandom_range(0, 3));
        end
        send_request(kind, status, d1, d2, count, setv);
    endtask

    initial
    begin : receiver
        int stall;
        int span;
        bit rx_quiet;
        stall    = 0;
        span     = 0;
        rx_quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span     = $urandom_range(50, 200);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            span--;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall = pick_gap(rx_quiet);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: nothing moved on either side for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] lo;
        logic [7:0] hi;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset limits of 0 and 128.
        send_request(KIND_SET, 8'h00, 7'd0, 7'd0, 2'd3, 8'd255);
        send_request(KIND_SET, 8'h00, 7'd127, 7'd0, 2'd3, 8'd0);
        send_request(KIND_SET, 8'hFF, 7'd64, 7'd127, 2'd0, 8'd128);
        send_request(KIND_SET, 8'h5A, 7'd65, 7'd33, 2'd1, 8'd77);
        send_request(KIND_MIDI, 8'hB0, 7'd0, 7'd63, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hB0, 7'd0, 7'd64, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hB0, 7'd0, 7'd127, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hB3, 7'd127, 7'd0, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hBF, 7'd127, 7'd65, 2'd3, 8'd255);
        send_request(KIND_MIDI, 8'hB7, 7'd5, 7'd1, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h90, 7'd0, 7'd127, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h9F, 7'd127, 7'd0, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h80, 7'd127, 7'd127, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h8A, 7'd3, 7'd0, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hB0, 7'd0, 7'd10, 2'd2, 8'd0);
        send_request(KIND_MIDI, 8'h90, 7'd9, 7'd100, 2'd0, 8'd0);
        send_request(KIND_MIDI, 8'h80, 7'd9, 7'd100, 2'd1, 8'd0);
        send_request(KIND_MIDI, 8'hA0, 7'd1, 7'd1, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hC5, 7'd1, 7'd1, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hE0, 7'd127, 7'd127, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'hF0, 7'd1, 7'd1, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h7F, 7'd1, 7'd1, 2'd3, 8'd0);
        send_request(KIND_MIDI, 8'h00, 7'd0, 7'd0, 2'd3, 8'd0);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin lo = 8'd0;   hi = 8'd128; end
                1: begin lo = 8'd128; hi = 8'd0;   end
                2: begin lo = 8'd40;  hi = 8'd90;  end
                3: begin lo = 8'd128; hi = 8'd128; end
                4: begin lo = 8'd0;   hi = 8'd0;   end
                default:
                begin
                    lo = 8'($urandom_range(0, 128));
                    hi = 8'($urandom_range(0, 128));
                end
            endcase
            set_limits(lo, hi);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i % 50 == 0)
                    tx_quiet = ($urandom_range(0, 3) == 0);
                if (i == RANDOM_PER_PHASE / 2)
                    wait_drained();
                send_random_request();
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Run covered %0d requests: %0d knob turns, %0d note on/off, %0d direct sets,",
                 n_turn + n_note + n_set + n_none, n_turn, n_note, n_set);
        $display("%0d with no event; limits reprogrammed %0d times, floor above ceiling included.",
                 n_none, n_phase);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
